// File: design/aed_pkg.sv
// Shared types and constants for the ANSI escape display decoder.
`default_nettype none

package aed_pkg;

  localparam int unsigned VAL_W = 14;
  localparam int unsigned ACC_W = VAL_W + 3;
  localparam logic [VAL_W-1:0] VALUE_CAP = 14'd9999;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_CSI,
    PH_FIELD
  } aed_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SGR,
    ST_OUT
  } aed_state_e;

  typedef enum logic [3:0] {
    CMD_PUT     = 4'd0,
    CMD_UP      = 4'd1,
    CMD_DOWN    = 4'd2,
    CMD_RIGHT   = 4'd3,
    CMD_LEFT    = 4'd4,
    CMD_MOVE    = 4'd5,
    CMD_ERASE   = 4'd6,
    CMD_CLR_EOL = 4'd7,
    CMD_SAVE    = 4'd8,
    CMD_RESTORE = 4'd9,
    CMD_ATTR    = 4'd10,
    CMD_FIELD   = 4'd11
  } aed_cmd_e;

  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_RIGHT  = 8'h43;
  localparam logic [7:0] CH_LEFT   = 8'h44;
  localparam logic [7:0] CH_MOVE   = 8'h48;
  localparam logic [7:0] CH_ERASE  = 8'h4A;
  localparam logic [7:0] CH_CLREOL = 8'h4B;
  localparam logic [7:0] CH_SGR    = 8'h6D;
  localparam logic [7:0] CH_SAVE   = 8'h73;
  localparam logic [7:0] CH_REST   = 8'h75;
  localparam logic [7:0] CH_F_S    = 8'h73;
  localparam logic [7:0] CH_F_N    = 8'h6E;
  localparam logic [7:0] CH_F_L    = 8'h6C;
  localparam logic [7:0] CH_F_T    = 8'h74;
  localparam logic [7:0] CH_F_B    = 8'h62;

  localparam logic [VAL_W-1:0] SGR_RESET      = 14'd0;
  localparam logic [VAL_W-1:0] SGR_BOLD       = 14'd1;
  localparam logic [VAL_W-1:0] SGR_FAINT      = 14'd2;
  localparam logic [VAL_W-1:0] SGR_UNDERLINE  = 14'd4;
  localparam logic [VAL_W-1:0] SGR_BLINK      = 14'd5;
  localparam logic [VAL_W-1:0] SGR_REVERSE    = 14'd7;
  localparam logic [VAL_W-1:0] SGR_BOLD_OFF   = 14'd21;
  localparam logic [VAL_W-1:0] SGR_NORMAL     = 14'd22;
  localparam logic [VAL_W-1:0] SGR_UNDER_OFF  = 14'd24;
  localparam logic [VAL_W-1:0] SGR_BLINK_OFF  = 14'd25;
  localparam logic [VAL_W-1:0] SGR_REV_OFF    = 14'd27;
  localparam logic [VAL_W-1:0] SGR_FG_LO      = 14'd30;
  localparam logic [VAL_W-1:0] SGR_FG_HI      = 14'd37;
  localparam logic [VAL_W-1:0] SGR_BG_LO      = 14'd40;
  localparam logic [VAL_W-1:0] SGR_BG_HI      = 14'd47;

  localparam logic [2:0] FG_DEFAULT = 3'd7;
  localparam logic [2:0] FG_UNDERLINE = 3'd4;

  typedef struct packed {
    logic reverse;
    logic blink;
    logic underline;
    logic bold;
  } aed_attr_t;

  typedef struct packed {
    logic       clear;
    logic       digit;
    logic       semi;
    logic [3:0] digit_val;
  } aed_pctl_t;

endpackage

`default_nettype wire

// File: design/aed_param_store.sv
// Parameter store of a control sequence with the shared times-ten accumulate unit.
`default_nettype none

module aed_param_store import aed_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 8,
  localparam int unsigned IDX_W = $clog2(MAX_PARAMS),
  localparam int unsigned CNT_W = $clog2(MAX_PARAMS + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire aed_pctl_t        pctl_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output logic [VAL_W-1:0]      rd_val_o,
  output logic [VAL_W-1:0]      val0_o,
  output logic [VAL_W-1:0]      val1_o,
  output logic [CNT_W-1:0]      count_o,
  output logic                  seen_digit_o,
  output logic                  first_empty_o
);

  logic [VAL_W-1:0] val_q [MAX_PARAMS];
  logic [CNT_W-1:0] count_q, count_d;
  logic             seen_q, seen_d;
  logic             first_empty_q, first_empty_d;
  logic             has_room;
  logic [IDX_W-1:0] wr_idx, rd_addr;
  logic [VAL_W-1:0] rd_val;
  logic [ACC_W-1:0] prod;
  logic [VAL_W-1:0] acc;

  assign has_room = count_q < CNT_W'(MAX_PARAMS);
  assign wr_idx   = has_room ? count_q[IDX_W-1:0] : '0;
  assign rd_addr  = pctl_i.digit ? wr_idx : rd_idx_i;
  assign rd_val   = val_q[rd_addr];

  // value * 10 + digit, saturating
  assign prod = ({3'b000, rd_val} << 3) + ({3'b000, rd_val} << 1)
              + ACC_W'(pctl_i.digit_val);
  assign acc  = (prod > ACC_W'(VALUE_CAP)) ? VALUE_CAP : prod[VAL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (pctl_i.clear) begin
      for (int i = 0; i < MAX_PARAMS; i++) begin
        val_q[i] <= '0;
      end
    end else if (pctl_i.digit && has_room) begin
      val_q[wr_idx] <= acc;
    end
  end

  always_comb begin
    count_d       = count_q;
    seen_d        = seen_q;
    first_empty_d = first_empty_q;
    if (pctl_i.clear) begin
      count_d       = '0;
      seen_d        = 1'b0;
      first_empty_d = 1'b1;
    end else if (pctl_i.digit) begin
      if (has_room) begin
        seen_d = 1'b1;
        if (count_q == '0) begin
          first_empty_d = 1'b0;
        end
      end
    end else if (pctl_i.semi) begin
      if (has_room) begin
        count_d = count_q + 1'b1;
      end
      seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      seen_q        <= 1'b0;
      first_empty_q <= 1'b1;
    end else begin
      count_q       <= count_d;
      seen_q        <= seen_d;
      first_empty_q <= first_empty_d;
    end
  end

  assign rd_val_o      = rd_val;
  assign val0_o        = val_q[0];
  assign val1_o        = val_q[1];
  assign count_o       = count_q;
  assign seen_digit_o  = seen_q;
  assign first_empty_o = first_empty_q;

endmodule

`default_nettype wire

// File: design/aed_sgr_unit.sv
// Attribute and color state with the unit that applies one SGR code per cycle.
`default_nettype none

module aed_sgr_unit import aed_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             apply_i,
  input  wire logic [VAL_W-1:0] code_i,
  output logic [5:0]            pair_o,
  output aed_attr_t             attr_o
);

  logic [2:0] fg_q, fg_d, bg_q, bg_d;
  logic [5:0] pair_q, pair_d;
  aed_attr_t  attr_q, attr_d;
  logic [VAL_W-1:0] fg_off, bg_off;

  assign fg_off = code_i - SGR_FG_LO;
  assign bg_off = code_i - SGR_BG_LO;

  always_comb begin
    fg_d   = fg_q;
    bg_d   = bg_q;
    pair_d = pair_q;
    attr_d = attr_q;
    if (apply_i) begin
      unique case (code_i) inside
        SGR_RESET: begin
          attr_d = '0;
          fg_d   = FG_DEFAULT;
          bg_d   = '0;
          pair_d = '0;
        end
        SGR_BOLD: attr_d.bold = 1'b1;
        SGR_FAINT, SGR_BOLD_OFF, SGR_NORMAL: attr_d.bold = 1'b0;
        SGR_UNDERLINE: begin
          attr_d.underline = 1'b1;
          fg_d             = FG_UNDERLINE;
        end
        SGR_BLINK: attr_d.blink = 1'b1;
        SGR_REVERSE, SGR_REV_OFF: begin
          attr_d.reverse = (code_i == SGR_REVERSE);
          fg_d           = bg_q;
          bg_d           = fg_q;
        end
        SGR_UNDER_OFF: attr_d.underline = 1'b0;
        SGR_BLINK_OFF: attr_d.blink = 1'b0;
        [SGR_FG_LO:SGR_FG_HI]: begin
          fg_d   = fg_off[2:0];
          pair_d = {bg_q, fg_off[2:0]};
        end
        [SGR_BG_LO:SGR_BG_HI]: begin
          bg_d   = bg_off[2:0];
          pair_d = {bg_off[2:0], fg_q};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q   <= FG_DEFAULT;
      bg_q   <= '0;
      pair_q <= '0;
      attr_q <= '0;
    end else begin
      fg_q   <= fg_d;
      bg_q   <= bg_d;
      pair_q <= pair_d;
      attr_q <= attr_d;
    end
  end

  assign pair_o = pair_q;
  assign attr_o = attr_q;

endmodule

`default_nettype wire

// File: design/ansi_escape_display_decoder.sv
// Top level: byte parser and sequencer of the ANSI escape display decoder.
// Order: a byte is accepted in ST_IDLE and decoded in the next cycle; a result
//   is valid in the cycle after decode, or for an SGR final with N applied fields
//   (N up to MAX_PARAMS) after ST_SGR has applied them, one field per cycle.
// A new byte is taken only in ST_IDLE, after any result has been handed off in ST_OUT.
// Reset: asynchronous active low; plain-text phase, default colors, no params.
`default_nettype none

module ansi_escape_display_decoder import aed_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           text_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [3:0]                command_o,
  output logic [VAL_W-1:0]          arg_first_o,
  output logic [VAL_W-1:0]          arg_second_o,
  output logic [5:0]                palette_idx_o,
  output logic                      bold_on_o,
  output logic                      underline_on_o,
  output logic                      blink_on_o,
  output logic                      reverse_on_o
);

  localparam int unsigned IDX_W = $clog2(MAX_PARAMS);
  localparam int unsigned CNT_W = $clog2(MAX_PARAMS + 1);

  aed_state_e state_q, state_d;
  aed_phase_e phase_q, phase_d;
  logic       quote_q, quote_d;
  logic [7:0] byte_q;
  logic [CNT_W-1:0] iter_q, iter_d, sgr_cnt;
  logic       iter_last;

  aed_cmd_e         cmd_q, cmd_d;
  logic [VAL_W-1:0] arg1_q, arg1_d, arg2_q, arg2_d;
  logic             out_load;

  aed_pctl_t        pctl;
  logic [VAL_W-1:0] rd_val, val0, val1;
  logic [CNT_W-1:0] pcount;
  logic             seen_digit, first_empty;
  logic [5:0]       pair;
  aed_attr_t        attr;

  logic             emit, start_sgr, is_digit, active;
  aed_cmd_e         emit_cmd;
  logic [VAL_W-1:0] emit_a, emit_b, mv_cnt, col, row;

  aed_param_store #(.MAX_PARAMS(MAX_PARAMS)) u_params (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pctl_i        (pctl),
    .rd_idx_i      (iter_q[IDX_W-1:0]),
    .rd_val_o      (rd_val),
    .val0_o        (val0),
    .val1_o        (val1),
    .count_o       (pcount),
    .seen_digit_o  (seen_digit),
    .first_empty_o (first_empty)
  );

  aed_sgr_unit u_sgr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .apply_i (state_q == ST_SGR),
    .code_i  (rd_val),
    .pair_o  (pair),
    .attr_o  (attr)
  );

  assign sgr_cnt   = (pcount < CNT_W'(MAX_PARAMS)) ? pcount + CNT_W'(seen_digit)
                                                   : CNT_W'(MAX_PARAMS);
  assign iter_last = (CNT_W'(iter_q + 1'b1) == sgr_cnt);
  assign is_digit  = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign active    = (state_q == ST_DECODE) && (byte_q != CH_CR);
  assign mv_cnt    = (val0 == '0) ? VAL_W'(1) : val0;
  assign col       = (first_empty || val0 == '0) ? '0 : val0 - 1'b1;
  assign row       = (first_empty || val1 == '0) ? '0 : val1 - 1'b1;

  // one parse step on the latched byte
  always_comb begin
    phase_d        = phase_q;
    quote_d        = quote_q;
    pctl           = '0;
    pctl.digit_val = byte_q[3:0];
    emit           = 1'b0;
    start_sgr      = 1'b0;
    emit_cmd       = CMD_PUT;
    emit_a         = '0;
    emit_b         = '0;
    if (active) begin
      unique case (phase_q)
        PH_TEXT: begin
          if (byte_q == CH_ESC) begin
            phase_d = PH_ESC;
          end else begin
            emit   = 1'b1;
            emit_a = VAL_W'(byte_q);
          end
        end
        PH_ESC: begin
          if (byte_q == CH_LBRACK) begin
            phase_d    = PH_CSI;
            pctl.clear = 1'b1;
          end else if (byte_q == CH_AT) begin
            phase_d    = PH_FIELD;
            pctl.clear = 1'b1;
          end
        end
        PH_CSI: begin
          if (is_digit) begin
            pctl.digit = 1'b1;
          end else if (byte_q == CH_SEMI) begin
            pctl.semi = 1'b1;
          end else begin
            phase_d = PH_TEXT;
            emit    = 1'b1;
            unique case (byte_q)
              CH_UP: begin
                emit_cmd = CMD_UP;
                emit_a   = mv_cnt;
              end
              CH_DOWN: begin
                emit_cmd = CMD_DOWN;
                emit_a   = mv_cnt;
              end
              CH_RIGHT: begin
                emit_cmd = CMD_RIGHT;
                emit_a   = mv_cnt;
              end
              CH_LEFT: begin
                emit_cmd = CMD_LEFT;
                emit_a   = mv_cnt;
              end
              CH_MOVE: begin
                emit_cmd = CMD_MOVE;
                emit_a   = col;
                emit_b   = row;
              end
              CH_ERASE:  emit_cmd = CMD_ERASE;
              CH_CLREOL: emit_cmd = CMD_CLR_EOL;
              CH_SAVE:   emit_cmd = CMD_SAVE;
              CH_REST:   emit_cmd = CMD_RESTORE;
              CH_SGR: begin
                emit      = 1'b0;
                start_sgr = 1'b1;
              end
              default: emit = 1'b0;
            endcase
          end
        end
        PH_FIELD: begin
          if (is_digit || byte_q == CH_DASH || byte_q == CH_SEMI ||
              byte_q == CH_QUOTE || quote_q) begin
            if (byte_q == CH_QUOTE) begin
              quote_d = !quote_q;
            end
          end else begin
            phase_d = PH_TEXT;
            quote_d = 1'b0;
            if (byte_q == CH_F_S || byte_q == CH_F_N || byte_q == CH_F_L ||
                byte_q == CH_F_T || byte_q == CH_F_B) begin
              emit     = 1'b1;
              emit_cmd = CMD_FIELD;
              emit_a   = VAL_W'(byte_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        if (start_sgr) begin
          state_d = (sgr_cnt == '0) ? ST_OUT : ST_SGR;
        end else if (emit) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SGR:    if (iter_last) state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    iter_d      = (state_q == ST_SGR) ? CNT_W'(iter_q + 1'b1) : '0;
    out_load    = ((state_q == ST_DECODE) && (emit || (start_sgr && sgr_cnt == '0))) ||
                  ((state_q == ST_SGR) && iter_last);
    cmd_d       = (start_sgr || state_q == ST_SGR) ? CMD_ATTR : emit_cmd;
    arg1_d      = emit_a;
    arg2_d      = emit_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_TEXT;
      quote_q <= 1'b0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      quote_q <= quote_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= text_byte_i;
    end
    if (out_load) begin
      cmd_q  <= cmd_d;
      arg1_q <= arg1_d;
      arg2_q <= arg2_d;
    end
  end

  assign command_o      = cmd_q;
  assign arg_first_o    = arg1_q;
  assign arg_second_o   = arg2_q;
  assign palette_idx_o  = pair;
  assign bold_on_o      = attr.bold;
  assign underline_on_o = attr.underline;
  assign blink_on_o     = attr.blink;
  assign reverse_on_o   = attr.reverse;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted item not decoded next cycle");

  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SGR) |-> (iter_q < sgr_cnt))
    else $error("SGR iteration past stored fields");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(command_o) && $stable(palette_idx_o)))
    else $error("pending result changed");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ANSI escape display decoder with an inline command predictor.
module tb;
  import aed_pkg::*;

  localparam int unsigned MAX_PARAMS  = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [VAL_W-1:0] arg_a;
    logic [VAL_W-1:0] arg_b;
    logic [5:0]       pair;
    aed_attr_t        attr;
  } display_cmd_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic [7:0]       text_byte_i = '0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [3:0]       command_o;
  logic [VAL_W-1:0] arg_first_o;
  logic [VAL_W-1:0] arg_second_o;
  logic [5:0]       palette_idx_o;
  logic             bold_on_o;
  logic             underline_on_o;
  logic             blink_on_o;
  logic             reverse_on_o;

  // decoder state mirror
  aed_phase_e       phase;
  logic [VAL_W-1:0] params [MAX_PARAMS];
  int unsigned      field_idx;
  logic             saw_digit;
  logic             first_empty;
  logic             in_quote;
  logic [2:0]       fg;
  logic [2:0]       bg;
  logic [5:0]       pair;
  aed_attr_t        attrs;

  display_cmd_t     pending_cmds[$];
  display_cmd_t     want;
  int unsigned      errors = 0;
  int unsigned      bytes_sent = 0;
  logic             idle_en = 1'b1;
  int unsigned      hold_requests = 0;
  int unsigned      hold_seen = 0;
  int unsigned      hold_left = 0;
  int unsigned      quiet_cycles = 0;

  ansi_escape_display_decoder #(.MAX_PARAMS(MAX_PARAMS)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_o      (command_o),
    .arg_first_o    (arg_first_o),
    .arg_second_o   (arg_second_o),
    .palette_idx_o  (palette_idx_o),
    .bold_on_o      (bold_on_o),
    .underline_on_o (underline_on_o),
    .blink_on_o     (blink_on_o),
    .reverse_on_o   (reverse_on_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void queue_display_cmd(aed_cmd_e cmd, logic [VAL_W-1:0] a,
                                            logic [VAL_W-1:0] b);
    display_cmd_t c;
    c.cmd   = cmd;
    c.arg_a = a;
    c.arg_b = b;
    c.pair  = pair;
    c.attr  = attrs;
    pending_cmds.push_back(c);
  endfunction

  function automatic void decode_byte(logic [7:0] c);
    int unsigned      v;
    int unsigned      n;
    int unsigned      cnt;
    logic [2:0]       t;
    logic [VAL_W-1:0] col;
    logic [VAL_W-1:0] row;
    logic [VAL_W-1:0] code;
    if (c == CH_CR) return;
    case (phase)
      PH_TEXT: begin
        if (c == CH_ESC) phase = PH_ESC;
        else queue_display_cmd(CMD_PUT, VAL_W'(c), '0);
      end
      PH_ESC: begin
        if (c == CH_LBRACK || c == CH_AT) begin
          phase = (c == CH_LBRACK) ? PH_CSI : PH_FIELD;
          foreach (params[i]) params[i] = '0;
          field_idx   = 0;
          saw_digit   = 1'b0;
          first_empty = 1'b1;
        end
      end
      PH_CSI: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (field_idx < MAX_PARAMS) begin
            v = params[field_idx] * 10 + (c - CH_ZERO);
            params[field_idx] = (v > VALUE_CAP) ? VALUE_CAP : VAL_W'(v);
            saw_digit = 1'b1;
            if (field_idx == 0) first_empty = 1'b0;
          end
        end else if (c == CH_SEMI) begin
          if (field_idx < MAX_PARAMS) field_idx++;
          saw_digit = 1'b0;
        end else begin
          phase = PH_TEXT;
          n = (params[0] == 0) ? 1 : params[0];
          case (c)
            CH_UP:     queue_display_cmd(CMD_UP, VAL_W'(n), '0);
            CH_DOWN:   queue_display_cmd(CMD_DOWN, VAL_W'(n), '0);
            CH_RIGHT:  queue_display_cmd(CMD_RIGHT, VAL_W'(n), '0);
            CH_LEFT:   queue_display_cmd(CMD_LEFT, VAL_W'(n), '0);
            CH_MOVE: begin
              col = first_empty ? '0 : params[0];
              row = first_empty ? '0 : params[1];
              if (col != 0) col--;
              if (row != 0) row--;
              queue_display_cmd(CMD_MOVE, col, row);
            end
            CH_ERASE:  queue_display_cmd(CMD_ERASE, '0, '0);
            CH_CLREOL: queue_display_cmd(CMD_CLR_EOL, '0, '0);
            CH_SAVE:   queue_display_cmd(CMD_SAVE, '0, '0);
            CH_REST:   queue_display_cmd(CMD_RESTORE, '0, '0);
            CH_SGR: begin
              cnt = (field_idx < MAX_PARAMS) ? field_idx + saw_digit : MAX_PARAMS;
              for (int i = 0; i < cnt; i++) begin
                code = params[i];
                case (code) inside
                  SGR_RESET: begin
                    attrs = '0;
                    fg    = FG_DEFAULT;
                    bg    = '0;
                    pair  = '0;
                  end
                  SGR_BOLD: attrs.bold = 1'b1;
                  SGR_FAINT, SGR_BOLD_OFF, SGR_NORMAL: attrs.bold = 1'b0;
                  SGR_UNDERLINE: begin
                    attrs.underline = 1'b1;
                    fg = FG_UNDERLINE;
                  end
                  SGR_BLINK: attrs.blink = 1'b1;
                  SGR_REVERSE, SGR_REV_OFF: begin
                    attrs.reverse = (code == SGR_REVERSE);
                    t  = fg;
                    fg = bg;
                    bg = t;
                  end
                  SGR_UNDER_OFF: attrs.underline = 1'b0;
                  SGR_BLINK_OFF: attrs.blink = 1'b0;
                  default: begin
                    if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
                      fg   = 3'(code - SGR_FG_LO);
                      pair = {bg, fg};
                    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
                      bg   = 3'(code - SGR_BG_LO);
                      pair = {bg, fg};
                    end
                  end
                endcase
              end
              queue_display_cmd(CMD_ATTR, '0, '0);
            end
            default: ;
          endcase
        end
      end
      default: begin
        if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DASH || c == CH_SEMI ||
            c == CH_QUOTE || in_quote) begin
          if (c == CH_QUOTE) in_quote = !in_quote;
        end else begin
          phase    = PH_TEXT;
          in_quote = 1'b0;
          if (c inside {CH_F_S, CH_F_N, CH_F_L, CH_F_T, CH_F_B})
            queue_display_cmd(CMD_FIELD, VAL_W'(c), '0);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string what, int unsigned exp_val, int unsigned got);
    if (exp_val != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, command %0d arg %0d", $time, command_o, arg_first_o);
      end else begin
        want = pending_cmds.pop_front();
        check_field("command", want.cmd, command_o);
        check_field("arg_first", want.arg_a, arg_first_o);
        check_field("arg_second", want.arg_b, arg_second_o);
        check_field("palette_idx", want.pair, palette_idx_o);
        check_field("bold_on", want.attr.bold, bold_on_o);
        check_field("underline_on", want.attr.underline, underline_on_o);
        check_field("blink_on", want.attr.blink, blink_on_o);
        check_field("reverse_on", want.attr.reverse, reverse_on_o);
      end
    end
  end

  // output side: random stalls plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen   <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idle_en && $urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else if (rst_ni) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (idle_en && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_csi(input string body);
    send_byte(CH_ESC);
    send_byte(CH_LBRACK);
    send_text(body);
  endtask

  task automatic send_field(input string body);
    send_byte(CH_ESC);
    send_byte(CH_AT);
    send_text(body);
  endtask

  function automatic int unsigned random_param();
    case ($urandom_range(9))
      0:       return $urandom_range(99999);
      1, 2:    return $urandom_range(9);
      default: return $urandom_range(48);
    endcase
  endfunction

  task automatic send_random_csi();
    string       finals = "ABCDHJKmsu";
    int unsigned fields;
    fields = ($urandom_range(9) == 0) ? $urandom_range(11, 5) : $urandom_range(4);
    send_byte(CH_ESC);
    send_byte(CH_LBRACK);
    for (int i = 0; i < fields; i++) begin
      if (i != 0) send_byte(CH_SEMI);
      if ($urandom_range(99) >= 15) send_text($sformatf("%0d", random_param()));
    end
    if ($urandom_range(99) < 85) send_byte(finals[$urandom_range(9)]);
    else send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_random_field();
    string      kinds = "snltb";
    string      body_chars = "0123456789-;\"";
    logic       quoted;
    logic [7:0] b;
    quoted = 1'b0;
    send_byte(CH_ESC);
    send_byte(CH_AT);
    repeat ($urandom_range(8)) begin
      if (quoted && $urandom_range(1)) b = 8'($urandom_range(255));
      else b = body_chars[$urandom_range(12)];
      if (b == CH_QUOTE) quoted = !quoted;
      send_byte(b);
    end
    if (quoted) send_byte(CH_QUOTE);
    if ($urandom_range(99) < 80) send_byte(kinds[$urandom_range(4)]);
    else send_byte(8'($urandom_range(255)));
  endtask

  task automatic run_random_stream(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
      else if (pick < 75) send_random_csi();
      else if (pick < 90) send_random_field();
      else repeat ($urandom_range(4, 1))
        send_byte(($urandom_range(3) == 0) ? CH_ESC : 8'($urandom_range(255)));
    end
  endtask

  task automatic test_plain_text();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(CH_CR);
    send_byte(8'hAA);
  endtask

  task automatic test_cursor_moves();
    send_csi("A");
    send_csi("5B");
    send_csi("0C");
    send_csi("99999D");
    send_csi("1\r2A");
    send_csi("H");
    send_csi("10;20H");
    send_csi(";5H");
    send_csi("1;1H");
    send_csi("J");
    send_csi("K");
    send_csi("s");
    send_csi("u");
    send_csi("3x");
    send_csi("5");
    send_byte(CH_ESC);
    send_csi("2;3;4;5;6;7;8;9;10;11A");
  endtask

  task automatic test_attributes();
    send_csi("m");
    send_csi("1;4;5;7m");
    send_csi("27;24;25;22m");
    send_csi("31;42m");
    send_csi("1;2m");
    send_csi("1;21m");
    send_csi("37;47;m");
    send_csi("33;;m");
    send_csi(";m");
    send_csi("30;31;32;33;34;35;36;37;40;41m");
    send_csi("0m");
  endtask

  task automatic test_escape_wait();
    send_byte(CH_ESC);
    send_text("x");
    send_byte(CH_ESC);
    send_byte(CH_CR);
    send_csi("2A");
  endtask

  task automatic test_field_markers();
    send_field("12;-3\"a b\"s");
    send_field("n");
    send_field("l");
    send_field("t");
    send_field("b");
    send_field("4x");
    send_field("\"q\rs\"t");
  endtask

  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    repeat (40) send_byte(8'($urandom_range(126, 32)));
  endtask

  task automatic test_no_idle_burst();
    idle_en <= 1'b0;
    run_random_stream(180);
    idle_en <= 1'b1;
  endtask

  initial begin
    phase       = PH_TEXT;
    foreach (params[i]) params[i] = '0;
    field_idx   = 0;
    saw_digit   = 1'b0;
    first_empty = 1'b1;
    in_quote    = 1'b0;
    fg          = FG_DEFAULT;
    bg          = '0;
    pair        = '0;
    attrs       = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_plain_text();
    test_cursor_moves();
    test_attributes();
    test_escape_wait();
    test_field_markers();
    test_backpressure();
    run_random_stream(400);
    test_no_idle_burst();

    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
